// ===== src/weighted_fair_queue_scheduler_unit_defines.svh =====
// assertion macros for the weighted fair queue scheduler
`ifndef WEIGHTED_FAIR_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define WEIGHTED_FAIR_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WFQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfqs assertion failed");
`define WFQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfqs assertion failed");
`else
`define WFQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WFQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/wfqs_pkg.sv =====
// shared types, constants and helpers of the weighted fair queue scheduler
package wfqs_pkg;

  localparam int QUEUES   = 4;
  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;
  localparam logic KIND_SENT = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  localparam logic [2:0] REG_RATE    = 3'd0;
  localparam logic [2:0] REG_WEIGHT0 = 3'd1;
  localparam logic [2:0] REG_WEIGHT1 = 3'd2;
  localparam logic [2:0] REG_WEIGHT2 = 3'd3;
  localparam logic [2:0] REG_WEIGHT3 = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] arr_time;
    logic [15:0] packet_id;
    logic [1:0]  queue_index;
    logic [15:0] packet_size;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] done_time;
    logic [15:0] sent_id;
    logic [1:0]  sent_queue;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] finish;
    logic [31:0] arrival;
    logic [15:0] id;
    logic [1:0]  queue;
    logic [15:0] size;
  } entry_t;

  typedef enum logic [1:0] {CELL_HOLD, CELL_INSERT, CELL_POP} cell_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEND_CHK, ST_SEND_DIV, ST_SEND_OUT,
    ST_STORE_CHK, ST_FIN_DIV, ST_INSERT, ST_DROP_OUT
  } state_t;

  // strict order on (finish, arrival, id)
  function automatic logic key_less(entry_t a, entry_t b);
    if (a.finish != b.finish) return a.finish < b.finish;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.id < b.id;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] base, logic [31:0] inc);
    logic [32:0] sum;
    sum = {1'b0, base} + {1'b0, inc};
    return sum[32] ? TIME_MAX : sum[31:0];
  endfunction

endpackage

// ===== src/wfqs_cell.sv =====
// one slot of the sorted packet chain
module wfqs_cell (
  input  logic               clk,
  input  wfqs_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               left_ge,
  input  wfqs_pkg::entry_t   new_entry,
  input  wfqs_pkg::entry_t   left_entry,
  input  wfqs_pkg::entry_t   right_entry,
  output logic               ge,
  output wfqs_pkg::entry_t   entry
);

  wfqs_pkg::entry_t entry_r;

  // new key sorts at or after this slot
  assign ge    = occupied && !wfqs_pkg::key_less(new_entry, entry_r);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    case (cmd)
      wfqs_pkg::CELL_INSERT: begin
        if (!ge) begin
          entry_r <= left_ge ? new_entry : left_entry;
        end
      end
      wfqs_pkg::CELL_POP: entry_r <= right_entry;
      default: entry_r <= entry_r;
    endcase
  end

endmodule

// ===== src/wfqs_div.sv =====
// restoring divider, one quotient bit per cycle
module wfqs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [15:0]         divisor,
  output wfqs_pkg::div_stat_t stat,
  output logic [31:0]         quotient
);

  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] shifted;
  logic [17:0] diff;

  always_comb begin
    shifted = {rem_r, quo_r[31]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    if (!diff[17]) begin
      rem_nxt = diff[15:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[15:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== src/weighted_fair_queue_scheduler_unit.sv =====
// top level of the weighted fair queue scheduler
// Packet-by-packet weighted fair queuing on real arrival time. Stored packets
// sit in a chain of CAPACITY slots kept sorted by (finish, arrival, id); an
// insert shifts the slots behind the new key one place right, a send shifts
// the whole chain one place left. All size/weight and size/rate quotients go
// through one shared restoring divider that retires one quotient bit a cycle.
// An arrival first sends stored packets while the line lags its arrival time
// (a flush sends all of them), each send waiting on out_ready, and is then
// stored or dropped. in_ready is high only while no item is in work. Each
// result beat is held in an output register; a drop beat carries done_time 0.
// Configuration writes (rate, weights) take effect at once and must come while
// the block is idle.
`include "weighted_fair_queue_scheduler_unit_defines.svh"
module weighted_fair_queue_scheduler_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wfqs_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wfqs_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  localparam int CW = wfqs_pkg::CNT_W;

  wfqs_pkg::state_t state_r, state_nxt;
  logic [15:0]      rate_r;
  logic [15:0]      weight_r [4];
  logic [31:0]      qlf_r [wfqs_pkg::QUEUES];
  logic [31:0]      lft_r;
  logic [CW-1:0]    count_r;
  wfqs_pkg::in_t    item_r;
  logic [31:0]      time_r, time_nxt;
  logic             out_valid_r;
  wfqs_pkg::out_t   out_data_r, out_nxt;

  // control of one sequence step
  logic             load_out, pop, insert, div_start, time_load;
  logic             slot_free, q_bad, is_flush, send_last;
  logic [31:0]      div_dividend;
  logic [15:0]      div_divisor, weight_sel;
  logic [31:0]      quotient, start_time, base_time;
  wfqs_pkg::div_stat_t div_stat;
  wfqs_pkg::cell_cmd_t cell_cmd;
  wfqs_pkg::entry_t    new_entry, head;
  wfqs_pkg::entry_t    cell_entry [wfqs_pkg::CAPACITY];
  logic [wfqs_pkg::CAPACITY-1:0] cell_ge;

  assign head       = cell_entry[0];
  assign slot_free  = !out_valid_r || out_ready;
  assign is_flush   = (item_r.opcode == wfqs_pkg::OP_FLUSH);
  assign q_bad      = ({1'b0, item_r.queue_index} >= 3'(wfqs_pkg::QUEUES));
  assign weight_sel = weight_r[item_r.queue_index];
  assign start_time = (lft_r > head.arrival) ? lft_r : head.arrival;
  assign base_time  = (qlf_r[item_r.queue_index] > item_r.arr_time) ?
                      qlf_r[item_r.queue_index] : item_r.arr_time;

  assign new_entry.finish  = time_r;
  assign new_entry.arrival = item_r.arr_time;
  assign new_entry.id      = item_r.packet_id;
  assign new_entry.queue   = item_r.queue_index;
  assign new_entry.size    = item_r.packet_size;

  // the send loop ends when the line catches up or the store runs dry
  assign send_last = is_flush ? (count_r == CW'(1)) :
                     (((time_r >= item_r.arr_time) || (count_r == CW'(1))) && !q_bad);

  wfqs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // sorted slot chain
  for (genvar i = 0; i < wfqs_pkg::CAPACITY; i++) begin : g_cell
    logic             left_ge;
    wfqs_pkg::entry_t left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_inner
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end
    if (i == wfqs_pkg::CAPACITY - 1) begin : g_last
      assign right_entry = new_entry;
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end
    wfqs_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .occupied    (CW'(i) < count_r),
      .left_ge     (left_ge),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .entry       (cell_entry[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_out     = 1'b0;
    pop          = 1'b0;
    insert       = 1'b0;
    div_start    = 1'b0;
    time_load    = 1'b0;
    time_nxt     = time_r;
    div_dividend = {head.size, 16'h0000};
    div_divisor  = rate_r;
    out_nxt      = out_data_r;
    in_ready     = 1'b0;
    unique case (state_r)
      wfqs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.opcode == wfqs_pkg::OP_FLUSH) begin
            state_nxt = wfqs_pkg::ST_SEND_CHK;
          end else if (lft_r >= in_data.arr_time) begin
            state_nxt = wfqs_pkg::ST_STORE_CHK;
          end else begin
            state_nxt = wfqs_pkg::ST_SEND_CHK;
          end
        end
      end
      wfqs_pkg::ST_SEND_CHK: begin
        if (count_r == '0) begin
          state_nxt = is_flush ? wfqs_pkg::ST_IDLE : wfqs_pkg::ST_STORE_CHK;
        end else begin
          div_start = 1'b1;
          state_nxt = wfqs_pkg::ST_SEND_DIV;
        end
      end
      wfqs_pkg::ST_SEND_DIV: begin
        if (div_stat.done) begin
          time_load = 1'b1;
          time_nxt  = (rate_r == '0) ? wfqs_pkg::TIME_MAX :
                      wfqs_pkg::sat_add(start_time, quotient);
          state_nxt = wfqs_pkg::ST_SEND_OUT;
        end
      end
      wfqs_pkg::ST_SEND_OUT: begin
        if (slot_free) begin
          load_out           = 1'b1;
          pop                = 1'b1;
          out_nxt.kind       = wfqs_pkg::KIND_SENT;
          out_nxt.done_time  = time_r;
          out_nxt.sent_id    = head.id;
          out_nxt.sent_queue = head.queue;
          out_nxt.last       = send_last;
          if (is_flush || time_r < item_r.arr_time) begin
            state_nxt = wfqs_pkg::ST_SEND_CHK;
          end else begin
            state_nxt = wfqs_pkg::ST_STORE_CHK;
          end
        end
      end
      wfqs_pkg::ST_STORE_CHK: begin
        if (q_bad || count_r >= CW'(wfqs_pkg::CAPACITY)) begin
          state_nxt = wfqs_pkg::ST_DROP_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = {item_r.packet_size, 16'h0000};
          div_divisor  = weight_sel;
          state_nxt    = wfqs_pkg::ST_FIN_DIV;
        end
      end
      wfqs_pkg::ST_FIN_DIV: begin
        if (div_stat.done) begin
          time_load = 1'b1;
          time_nxt  = (weight_sel == '0) ? wfqs_pkg::TIME_MAX :
                      wfqs_pkg::sat_add(base_time, quotient);
          state_nxt = wfqs_pkg::ST_INSERT;
        end
      end
      wfqs_pkg::ST_INSERT: begin
        insert    = 1'b1;
        state_nxt = wfqs_pkg::ST_IDLE;
      end
      wfqs_pkg::ST_DROP_OUT: begin
        if (slot_free) begin
          load_out           = 1'b1;
          out_nxt.kind       = wfqs_pkg::KIND_DROP;
          out_nxt.done_time  = '0;
          out_nxt.sent_id    = item_r.packet_id;
          out_nxt.sent_queue = item_r.queue_index;
          out_nxt.last       = 1'b1;
          state_nxt          = wfqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wfqs_pkg::ST_IDLE;
    endcase
  end

  assign cell_cmd = insert ? wfqs_pkg::CELL_INSERT :
                    pop    ? wfqs_pkg::CELL_POP : wfqs_pkg::CELL_HOLD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wfqs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 16'd256;
      for (int k = 0; k < 4; k++) weight_r[k] <= 16'd256;
      for (int k = 0; k < wfqs_pkg::QUEUES; k++) qlf_r[k] <= '0;
      lft_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wfqs_pkg::REG_RATE:    rate_r      <= cfg_wdata;
          wfqs_pkg::REG_WEIGHT0: weight_r[0] <= cfg_wdata;
          wfqs_pkg::REG_WEIGHT1: weight_r[1] <= cfg_wdata;
          wfqs_pkg::REG_WEIGHT2: weight_r[2] <= cfg_wdata;
          wfqs_pkg::REG_WEIGHT3: weight_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (pop) begin
        lft_r   <= time_r;
        count_r <= count_r - CW'(1);
      end
      if (insert) begin
        count_r                     <= count_r + CW'(1);
        qlf_r[item_r.queue_index]   <= time_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_data;
    if (time_load) time_r <= time_nxt;
    if (load_out) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WFQS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(wfqs_pkg::CAPACITY))
  `WFQS_ASSERT_IMP(a_div_done_state, clk, rst_n, div_stat.done, state_r == wfqs_pkg::ST_SEND_DIV || state_r == wfqs_pkg::ST_FIN_DIV)
  `WFQS_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_r == wfqs_pkg::ST_IDLE, !div_stat.busy)
  `WFQS_ASSERT_NXT(a_insert_count, clk, rst_n, state_r == wfqs_pkg::ST_INSERT, count_r == $past(count_r) + CW'(1))

endmodule
